// ===== sv/fsd_pkg.sv =====
package fsd_pkg;

  // Default depth of the pattern store and of the text window
  localparam int unsigned MAX_PATTERN_DEF = 32;

  localparam int unsigned BYTE_W = 8;

  // Widths of the stream words
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 8;

  // Kind of an input word
  typedef enum logic [0:0] {
    FUNC_PATTERN = 1'b0,
    FUNC_TEXT    = 1'b1
  } func_e;

  // Verdict codes
  typedef enum logic [1:0] {
    VERDICT_NO_MATCH = 2'd0,
    VERDICT_MATCH    = 2'd1,
    VERDICT_MISSING  = 2'd2,
    VERDICT_TOO_LONG = 2'd3
  } verdict_e;

  // One accepted input word, unpacked
  typedef struct packed {
    func_e                func;
    logic [BYTE_W-1:0]    data_byte;
    logic                 has_byte;
    logic                 last_of_string;
    logic                 is_missing;
  } item_t;

  // Flags of the stored pattern
  typedef struct packed {
    logic missing;
    logic overflow;
  } pat_status_t;

endpackage

// ===== sv/fsd_pattern.sv =====
module fsd_pattern #(
  parameter int unsigned MAX_PATTERN = fsd_pkg::MAX_PATTERN_DEF,
  parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  upd_i,
  input  fsd_pkg::item_t                        item_i,
  output logic [MAX_PATTERN-1:0][7:0]           pat_o,
  output logic [LEN_W-1:0]                      pat_len_o,
  output fsd_pkg::pat_status_t                  pat_status_o
);
  import fsd_pkg::*;

  // Newest pattern byte sits at index 0
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_q;
  logic [LEN_W-1:0]                   len_q, len_d;
  logic                               closed_q, closed_d;
  logic                               missing_q, missing_d;
  logic                               overflow_q, overflow_d;
  logic [LEN_W-1:0]                   base_len;
  logic                               shift_en;

  // Start a new pattern after a closed one, then append the word
  always_comb begin
    base_len   = closed_q ? '0 : len_q;
    len_d      = len_q;
    closed_d   = closed_q;
    missing_d  = missing_q;
    overflow_d = overflow_q;
    shift_en   = 1'b0;
    if (upd_i) begin
      len_d      = base_len;
      missing_d  = (missing_q & ~closed_q) | item_i.is_missing;
      overflow_d = overflow_q & ~closed_q;
      closed_d   = item_i.last_of_string;
      if (item_i.has_byte) begin
        if (base_len < LEN_W'(MAX_PATTERN)) begin
          len_d    = base_len + LEN_W'(1);
          shift_en = 1'b1;
        end else begin
          overflow_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      closed_q   <= 1'b0;
      missing_q  <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      len_q      <= len_d;
      closed_q   <= closed_d;
      missing_q  <= missing_d;
      overflow_q <= overflow_d;
    end
  end

  // Shift the pattern bytes; entries past the length are never compared
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      pat_q[0] <= item_i.data_byte;
      for (int unsigned i = 1; i < MAX_PATTERN; i++) begin
        pat_q[i] <= pat_q[i-1];
      end
    end
  end

  assign pat_o                 = pat_q;
  assign pat_len_o             = len_q;
  assign pat_status_o.missing  = missing_q;
  assign pat_status_o.overflow = overflow_q;

endmodule

// ===== sv/fsd_text.sv =====
module fsd_text #(
  parameter int unsigned MAX_PATTERN = fsd_pkg::MAX_PATTERN_DEF,
  parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  upd_i,
  input  fsd_pkg::item_t                        item_i,
  input  logic [MAX_PATTERN-1:0][7:0]           pat_i,
  input  logic [LEN_W-1:0]                      pat_len_i,
  input  fsd_pkg::pat_status_t                  pat_status_i,
  output fsd_pkg::verdict_e                     verdict_o
);
  import fsd_pkg::*;

  // Newest text byte sits at index 0
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_q;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_new;
  logic [LEN_W-1:0]                   count_q, count_d, count_new;
  logic                               match_q, match_d;
  logic                               tmiss_q, tmiss_d;
  logic [MAX_PATTERN-1:0]             lane_ok;
  logic                               hit;
  logic                               match_now;
  logic                               tmiss_now;

  // Window as it stands after this byte
  always_comb begin
    win_new[0] = item_i.data_byte;
    for (int unsigned i = 1; i < MAX_PATTERN; i++) begin
      win_new[i] = win_q[i-1];
    end
  end

  assign count_new = (count_q < LEN_W'(MAX_PATTERN)) ? count_q + LEN_W'(1) : count_q;

  // Compare each window lane with the pattern lane of the same age
  always_comb begin
    for (int unsigned i = 0; i < MAX_PATTERN; i++) begin
      lane_ok[i] = (LEN_W'(i) >= pat_len_i) || (win_new[i] == pat_i[i]);
    end
  end

  assign hit       = (count_new >= pat_len_i) && (&lane_ok);
  assign match_now = match_q | (item_i.has_byte & hit);
  assign tmiss_now = tmiss_q | item_i.is_missing;

  // Verdict priority: missing, then too long, then match
  always_comb begin
    if (tmiss_now || pat_status_i.missing) begin
      verdict_o = VERDICT_MISSING;
    end else if (pat_status_i.overflow) begin
      verdict_o = VERDICT_TOO_LONG;
    end else if (match_now) begin
      verdict_o = VERDICT_MATCH;
    end else begin
      verdict_o = VERDICT_NO_MATCH;
    end
  end

  // Advance the text state, clear it at the end of a string
  always_comb begin
    count_d = count_q;
    match_d = match_q;
    tmiss_d = tmiss_q;
    if (upd_i) begin
      if (item_i.last_of_string) begin
        count_d = '0;
        match_d = 1'b0;
        tmiss_d = 1'b0;
      end else begin
        count_d = item_i.has_byte ? count_new : count_q;
        match_d = match_now;
        tmiss_d = tmiss_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      match_q <= 1'b0;
      tmiss_q <= 1'b0;
    end else begin
      count_q <= count_d;
      match_q <= match_d;
      tmiss_q <= tmiss_d;
    end
  end

  // Lanes past the byte count are masked by the count check
  always_ff @(posedge clk_i) begin
    if (upd_i && item_i.has_byte) begin
      win_q <= win_new;
    end
  end

endmodule

// ===== sv/fixed_substring_detector.sv =====
// Channel   Dir  Word layout
// s_axis    in   tdata[7:0] data_byte, [8] has_byte, [9] is_missing; tuser func; tlast last_of_string
// m_axis    out  tdata[1:0] verdict, upper bits zero
//
// An accepted word sits in the input register until it advances; the pattern and
// window compare runs combinationally from it and the verdict lands in the output register.
// One word per cycle outside the stall below; the full parallel window compare sets the path.
// Reset clears lengths, counts and flags; pattern bytes stay unknown until written.
// A held verdict stalls only a text word that ends a string; others flow on.
module fixed_substring_detector #(
  parameter int unsigned MAX_PATTERN = fsd_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fsd_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // data_byte, has_byte, is_missing
  input  logic [fsd_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // func
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [fsd_pkg::M_TDATA_W-1:0]  m_axis_tdata   // verdict
);
  import fsd_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  logic                               s1_valid_q;
  item_t                              s1_item_q;
  item_t                              in_item;
  logic                               s1_produces;
  logic                               s1_advance;
  logic                               m_valid_q;
  verdict_e                           verdict_q;
  verdict_e                           verdict;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat;
  logic [LEN_W-1:0]                   pat_len;
  pat_status_t                        pat_status;

  // Unpack the input word
  assign in_item.func           = func_e'(s_axis_tuser[0]);
  assign in_item.data_byte      = s_axis_tdata[7:0];
  assign in_item.has_byte       = s_axis_tdata[8];
  assign in_item.is_missing     = s_axis_tdata[9];
  assign in_item.last_of_string = s_axis_tlast;

  // Only a text word that ends a string needs the output register
  assign s1_produces   = (s1_item_q.func == FUNC_TEXT) && s1_item_q.last_of_string;
  assign s1_advance    = s1_valid_q && (!s1_produces || !m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item_q <= in_item;
    end
  end

  fsd_pattern #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_pattern (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (s1_advance && (s1_item_q.func == FUNC_PATTERN)),
    .item_i       (s1_item_q),
    .pat_o        (pat),
    .pat_len_o    (pat_len),
    .pat_status_o (pat_status)
  );

  fsd_text #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_text (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (s1_advance && (s1_item_q.func == FUNC_TEXT)),
    .item_i       (s1_item_q),
    .pat_i        (pat),
    .pat_len_i    (pat_len),
    .pat_status_i (pat_status),
    .verdict_o    (verdict)
  );

  // Output register: load a verdict, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_advance && s1_produces) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_produces) begin
      verdict_q <= verdict;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-2){1'b0}}, verdict_q};

endmodule

// ===== dv/tb_fixed_substring_detector.sv =====
`timescale 1ns / 100ps

module tb_fixed_substring_detector;
  import fsd_pkg::*;

  localparam int unsigned MAXP        = MAX_PATTERN_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 150;

  typedef bit [7:0] octet_q_t [$];

  // Clock, reset and driven stream signals, all known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // data_byte, has_byte, is_missing
  logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;  // func
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;        // verdict

  fixed_substring_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the detector state
  bit [7:0]    pat_bytes [MAXP];
  int unsigned pat_len    = 0;
  bit          pat_closed = 1'b0;
  bit          pat_na     = 1'b0;
  bit          pat_over   = 1'b0;
  bit [7:0]    win [MAXP];
  int unsigned txt_count  = 0;
  bit          hit_seen   = 1'b0;
  bit          txt_na     = 1'b0;

  verdict_e    pending_verdicts [$];

  // Run bookkeeping
  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned verdict_tally [4];
  bit          tx_idle_on     = 1'b1;
  bit          rx_idle_on     = 1'b1;
  logic        rx_hold        = 1'b0;
  int unsigned rx_wait        = 0;

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endfunction

  // Advance the shadow state by one accepted word; queue a verdict on text end
  function automatic void predict_verdict(input func_e f, input logic [7:0] b,
                                          input logic has, input logic last,
                                          input logic miss);
    int i;
    bit hit;
    if (f == FUNC_PATTERN) begin
      // a pattern word after a closed pattern starts a new one
      if (pat_closed) begin
        pat_len    = 0;
        pat_na     = 1'b0;
        pat_over   = 1'b0;
        pat_closed = 1'b0;
      end
      if (miss) pat_na = 1'b1;
      if (has) begin
        if (pat_len < MAXP) begin
          pat_bytes[pat_len] = b;
          pat_len++;
        end else begin
          pat_over = 1'b1;
        end
      end
      if (last) pat_closed = 1'b1;
      return;
    end
    if (miss) txt_na = 1'b1;
    if (has) begin
      for (i = MAXP - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      if (txt_count < MAXP) txt_count++;
      // newest bytes against the whole pattern as it stands now
      hit = (txt_count >= pat_len);
      for (i = 0; i < int'(pat_len); i++) begin
        if (win[i] != pat_bytes[pat_len-1-i]) hit = 1'b0;
      end
      if (hit) hit_seen = 1'b1;
    end
    if (last) begin
      if (txt_na || pat_na)   pending_verdicts.push_back(VERDICT_MISSING);
      else if (pat_over)      pending_verdicts.push_back(VERDICT_TOO_LONG);
      else if (hit_seen)      pending_verdicts.push_back(VERDICT_MATCH);
      else                    pending_verdicts.push_back(VERDICT_NO_MATCH);
      for (i = 0; i < int'(MAXP); i++) win[i] = 8'h00;
      txt_count = 0;
      hit_seen  = 1'b0;
      txt_na    = 1'b0;
    end
  endfunction

  // Mostly a small alphabet so that matches happen, now and then any byte
  function automatic bit [7:0] pick_byte();
    if ($urandom_range(0, 6) == 0) return 8'($urandom);
    return 8'h41 + 8'($urandom_range(0, 2));
  endfunction

  // Offer one word, after a random gap if idle gaps are on, and hold it until accepted
  task automatic send_word(input func_e f, input logic [7:0] b, input logic has,
                           input logic last, input logic miss);
    logic [S_TDATA_W-1:0] word;
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word       = '0;
    word[7:0]  = b;
    word[8]    = has;
    word[9]    = miss;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= f;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_verdict(f, b, has, last, miss);
    items_sent++;
  endtask

  // Send one pattern or text; optional NA mark, empty fillers, stray pattern word
  task automatic send_string(input func_e f, input octet_q_t str, input bit na,
                             input bit noisy);
    int  n;
    int  na_at;
    int  noise_at;
    int  k;
    bit  pad_last;
    n        = str.size();
    pad_last = (n == 0) || ($urandom_range(0, 5) == 0);
    na_at    = na ? $urandom_range(0, pad_last ? n : n - 1) : -1;
    noise_at = noisy ? $urandom_range(0, n) : -1;
    for (k = 0; k < n; k++) begin
      if (k == noise_at) begin
        send_word(FUNC_PATTERN, pick_byte(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0);
      end
      if ($urandom_range(0, 15) == 0) send_word(f, 8'($urandom), 1'b0, 1'b0, 1'b0);
      send_word(f, str[k], 1'b1, (k == n - 1) && !pad_last, k == na_at);
    end
    if (pad_last) send_word(f, 8'($urandom), 1'b0, 1'b1, na_at == n);
  endtask

  // Empty strings, byte extremes, NA marks and a pattern changed mid-text
  task automatic test_special_cases();
    octet_q_t s;
    tx_idle_on = 1'b0;
    // no pattern yet: empty text never matches, one byte matches
    send_word(FUNC_TEXT, 8'h00, 1'b0, 1'b1, 1'b0);
    send_word(FUNC_TEXT, 8'hFF, 1'b1, 1'b1, 1'b0);
    tx_idle_on = 1'b1;
    s = '{8'h00, 8'hFF};
    send_string(FUNC_PATTERN, s, 1'b0, 1'b0);
    send_word(FUNC_TEXT, 8'h00, 1'b1, 1'b0, 1'b0);
    send_word(FUNC_TEXT, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_word(FUNC_TEXT, 8'hFF, 1'b1, 1'b0, 1'b0);
    send_word(FUNC_TEXT, 8'h00, 1'b1, 1'b1, 1'b0);
    // empty text against a real pattern
    send_word(FUNC_TEXT, 8'hAA, 1'b0, 1'b1, 1'b0);
    // empty NA pattern
    send_word(FUNC_PATTERN, 8'h55, 1'b0, 1'b1, 1'b1);
    send_word(FUNC_TEXT, 8'h12, 1'b1, 1'b1, 1'b0);
    // NA text, marked on an empty word
    send_word(FUNC_PATTERN, 8'h5A, 1'b1, 1'b1, 1'b0);
    send_word(FUNC_TEXT, 8'h00, 1'b0, 1'b0, 1'b1);
    send_word(FUNC_TEXT, 8'h5A, 1'b1, 1'b1, 1'b0);
    // pattern rebuilt while a text is open; the hit stays sticky
    send_word(FUNC_PATTERN, 8'hA5, 1'b1, 1'b0, 1'b0);
    send_word(FUNC_TEXT, 8'hA5, 1'b1, 1'b0, 1'b0);
    send_word(FUNC_PATTERN, 8'h3C, 1'b1, 1'b1, 1'b0);
    send_word(FUNC_TEXT, 8'h77, 1'b1, 1'b1, 1'b0);
  endtask

  // Full store, overflow, long texts and verdict priority
  task automatic test_store_limits();
    octet_q_t pat;
    octet_q_t txt;
    int k;
    pat = {};
    for (k = 0; k < int'(MAXP); k++) pat.push_back(8'($urandom));
    send_string(FUNC_PATTERN, pat, 1'b0, 1'b0);
    txt = {8'($urandom), 8'($urandom), 8'($urandom)};
    for (k = 0; k < int'(MAXP); k++) txt.push_back(pat[k]);
    send_string(FUNC_TEXT, txt, 1'b0, 1'b0);
    // one byte off, then a text longer than the window
    txt = pat;
    txt[$urandom_range(0, MAXP - 1)] ^= 8'h80;
    send_string(FUNC_TEXT, txt, 1'b0, 1'b0);
    txt = {};
    for (k = 0; k < 40; k++) txt.push_back(pick_byte());
    send_string(FUNC_TEXT, txt, 1'b0, 1'b0);
    // overflowed pattern: too long, unless a string is NA
    pat.push_back(8'hFF);
    pat.push_back(8'h00);
    send_string(FUNC_PATTERN, pat, 1'b0, 1'b0);
    send_string(FUNC_TEXT, pat, 1'b0, 1'b0);
    txt = {8'h41};
    send_string(FUNC_TEXT, txt, 1'b1, 1'b0);
    send_string(FUNC_PATTERN, pat, 1'b1, 1'b0);
    send_string(FUNC_TEXT, txt, 1'b0, 1'b0);
  endtask

  // Well-formed pattern/text runs with random content, some noise mixed in
  task automatic test_random_strings(input int unsigned n_items);
    int unsigned stop_at;
    octet_q_t    pat;
    octet_q_t    txt;
    int          len;
    int          r;
    int          k;
    stop_at = items_sent + n_items;
    pat = {};
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) tx_idle_on = !tx_idle_on;
      if ($urandom_range(0, 9) == 0) rx_idle_on = !rx_idle_on;
      // fresh pattern now and then; mostly short, a few full or overflowing
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 19);
        if (r < 2)        len = 0;
        else if (r < 16)  len = $urandom_range(1, 4);
        else if (r < 19)  len = $urandom_range(5, MAXP);
        else              len = $urandom_range(MAXP + 1, MAXP + 4);
        pat = {};
        for (k = 0; k < len; k++) pat.push_back(pick_byte());
        send_string(FUNC_PATTERN, pat, $urandom_range(0, 24) == 0, 1'b0);
      end
      txt = {};
      len = $urandom_range(0, 10);
      for (k = 0; k < len; k++) txt.push_back(pick_byte());
      if ($urandom_range(0, 9) < 4) begin
        for (k = 0; k < pat.size(); k++) txt.push_back(pat[k]);
        len = $urandom_range(0, 3);
        for (k = 0; k < len; k++) txt.push_back(pick_byte());
      end
      send_string(FUNC_TEXT, txt, $urandom_range(0, 24) == 0, $urandom_range(0, 19) == 0);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Hold the verdict side off while short texts keep coming
  task automatic test_output_backpressure();
    octet_q_t txt;
    int k;
    tx_idle_on = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      for (k = 0; k < 16; k++) begin
        txt = {pick_byte()};
        send_string(FUNC_TEXT, txt, 1'b0, 1'b0);
      end
    join
    tx_idle_on = 1'b1;
  endtask

  // Verdict side readiness: random stall per word if idle gaps are on, long hold on request
  always @(posedge clk_i or negedge rst_ni) begin : rx_pace
    int stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall = rx_idle_on ? $urandom_range(0, 11) : 0;
      rx_wait       <= stall;
      m_axis_tready <= (stall == 0);
    end else if (rx_wait != 0) begin
      rx_wait       <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted verdict with the oldest expected one
  always @(posedge clk_i) begin : check_verdicts
    verdict_e got;
    verdict_e want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = verdict_e'(m_axis_tdata[1:0]);
      verdict_tally[got]++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("verdict %s with none expected", got.name()));
      end else begin
        want = pending_verdicts.pop_front();
        if (got != want) begin
          flag_mismatch($sformatf("verdict expected %s, got %s", want.name(), got.name()));
        end
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, pending_verdicts.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_store_limits();
    test_random_strings(RANDOM_ITEMS);
    test_output_backpressure();

    // the last word was taken at this edge; stop offering it
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (pending_verdicts.size() != 0) begin
      flag_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    end
    $display("covered %0d input words over %0d cycles; %0d mismatches",
             items_sent, cycle_count, mismatch_count);
    $display("verdicts seen: no match %0d, match %0d, missing %0d, too long %0d",
             verdict_tally[VERDICT_NO_MATCH], verdict_tally[VERDICT_MATCH],
             verdict_tally[VERDICT_MISSING], verdict_tally[VERDICT_TOO_LONG]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fsd_pkg.sv
sv/fsd_pattern.sv
sv/fsd_text.sv
sv/fixed_substring_detector.sv
dv/tb_fixed_substring_detector.sv
